// ----- rtl/mcprd_pkg.sv -----
// Package for the multi-channel pulse relay driver.
// Holds operation, test mode, status and register index codes and fixed field widths.
// No dependencies.
package mcprd_pkg;

  localparam int unsigned PIN_W     = 48;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DUR_W     = 24;

  localparam logic [DUR_W-1:0] DEFAULT_HOLD = 24'd1000;

  typedef enum logic [3:0] {
    OP_TICK      = 4'd0,
    OP_ACT_PROD  = 4'd1,
    OP_ACT_DIAG  = 4'd2,
    OP_ALL_ON    = 4'd3,
    OP_ALL_OFF   = 4'd4,
    OP_CYC_ALL   = 4'd5,
    OP_CYC_CH    = 4'd6,
    OP_CYC_BD    = 4'd7,
    OP_STOP      = 4'd8
  } op_e;

  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_ALL_ON  = 3'd1;
  localparam logic [2:0] MODE_ALL_OFF = 3'd2;
  localparam logic [2:0] MODE_CYC_ALL = 3'd3;
  localparam logic [2:0] MODE_CYC_CH  = 3'd4;
  localparam logic [2:0] MODE_CYC_BD  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_OFFLINE = 2'd2;

  localparam logic [1:0] REG_BOARD_MASK = 2'd0;
  localparam logic [1:0] REG_ACT_HIGH   = 2'd1;
  localparam logic [1:0] REG_PROD_LIMIT = 2'd2;

endpackage

// ----- rtl/mcprd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mcprd_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/multi_channel_pulse_relay_driver.sv -----
// Multi-channel pulse relay driver, top level.
// Uses mcprd_pkg and mcprd_ram (per-channel pulse timer store).
//
// One transaction in, one result out. A tick bumps the millisecond counter and then
// walks the timer RAM one channel per cycle, releasing expired pulses, before the
// cycling test mode is checked. Every other operation passes through an execute
// state and then the completion state. Results sit in an output register, so a
// new transaction is taken while the previous result waits. Configuration registers
// are written through the APB port at byte addresses 0, 4 and 8 and must only
// change while idle.
module multi_channel_pulse_relay_driver #(
  parameter int unsigned CHANNELS       = 48,
  parameter int unsigned BOARDS         = 3,
  parameter int unsigned PINS_PER_BOARD = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // operation[3:0], channel[9:4], board[11:10], duration_ms[35:12], hold_ms[59:36]
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pin_levels[47:0], status[49:48], cycle_phase[50]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW    = $clog2(CHANNELS);
  localparam int unsigned CNT_W = $clog2(CHANNELS + 1);
  localparam int unsigned TW    = mcprd_pkg::TIME_W;
  localparam int unsigned DW    = mcprd_pkg::DUR_W;
  localparam int unsigned RAM_W = TW + DW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SWEEP  = 3'd2;
  localparam logic [2:0] S_TOGGLE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // configuration
  logic [2:0] board_mask_q;
  logic       act_high_q;
  logic [5:0] prod_limit_q;
  logic       cfg_wr;

  // control and state
  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                rd_vld_q;
  logic [AW-1:0]       rd_idx_q;
  logic [TW-1:0]       time_q, time_d;
  logic [TW-1:0]       last_q, last_d;
  logic [DW-1:0]       hold_q, hold_d;
  logic [5:0]          tc_q, tc_d;
  logic [1:0]          tb_q, tb_d;
  logic                phase_q, phase_d;
  logic [2:0]          mode_q, mode_d;
  logic [CHANNELS-1:0] en_q, en_d;
  logic [CHANNELS-1:0] run_q, run_d;
  logic [1:0]          status_q, status_d;

  // latched transaction
  mcprd_pkg::op_e op_q;
  logic [5:0]     ch_q;
  logic [1:0]     bd_q;
  logic [DW-1:0]  dur_q;
  logic [DW-1:0]  hold_in_q;

  // output register
  logic                        m_valid_q;
  logic [mcprd_pkg::OUT_DATA_W-1:0] m_data_q;

  // masks
  logic [3:0]          bd_up;
  logic [CHANNELS-1:0] online;
  logic [CHANNELS-1:0] new_ch_mask, old_ch_mask, new_bd_mask, old_bd_mask;
  logic [CHANNELS-1:0] cur_mask;
  logic [CHANNELS-1:0] pin_full;
  logic [mcprd_pkg::PIN_W-1:0] pin_out;

  // timer RAM
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;
  logic [5:0]       wr_idx;
  logic [TW-1:0]    elapsed;
  logic             expired;
  logic [TW-1:0]    since_toggle;
  logic             in_acc;
  logic             ch_in_range, act_ok;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_mask_q <= 3'd0;
      act_high_q   <= 1'b1;
      prod_limit_q <= 6'd47;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mcprd_pkg::REG_BOARD_MASK: board_mask_q <= pwdata[2:0];
        mcprd_pkg::REG_ACT_HIGH:   act_high_q   <= pwdata[0];
        mcprd_pkg::REG_PROD_LIMIT: prod_limit_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mcprd_pkg::REG_BOARD_MASK: prdata = {29'd0, board_mask_q};
      mcprd_pkg::REG_ACT_HIGH:   prdata = {31'd0, act_high_q};
      mcprd_pkg::REG_PROD_LIMIT: prdata = {26'd0, prod_limit_q};
      default:                   prdata = 32'd0;
    endcase
  end

  for (genvar j = 0; j < 4; j++) begin : g_bd
    if (j < BOARDS && j < 3) begin : g_up
      assign bd_up[j] = board_mask_q[j];
    end else begin : g_down
      assign bd_up[j] = 1'b0;
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
    localparam int unsigned BI = i / PINS_PER_BOARD;
    if (BI < 4) begin : g_on
      assign online[i] = bd_up[BI];
    end else begin : g_off
      assign online[i] = 1'b0;
    end
    assign new_ch_mask[i] = ({1'b0, ch_q} == 7'(i + 1));
    assign old_ch_mask[i] = ({1'b0, tc_q} == 7'(i + 1));
    assign new_bd_mask[i] = (3'(BI) == {1'b0, bd_q});
    assign old_bd_mask[i] = (3'(BI) == {1'b0, tb_q});
  end

  // pins driven by the running test mode
  always_comb begin
    case (mode_q)
      mcprd_pkg::MODE_ALL_ON, mcprd_pkg::MODE_ALL_OFF,
      mcprd_pkg::MODE_CYC_ALL: cur_mask = online;
      mcprd_pkg::MODE_CYC_CH:  cur_mask = old_ch_mask & online;
      mcprd_pkg::MODE_CYC_BD:  cur_mask = old_bd_mask & online;
      default:                 cur_mask = '0;
    endcase
  end

  assign in_acc       = s_axis_tvalid && s_axis_tready;
  assign wr_idx       = 6'(ch_q - 6'd1);
  assign elapsed      = time_q - ram_rdata[RAM_W-1:DW];
  assign expired      = elapsed >= {{(TW - DW){1'b0}}, ram_rdata[DW-1:0]};
  assign since_toggle = time_q - last_q;
  assign ch_in_range  = (ch_q != 6'd0) && ({1'b0, ch_q} <= 7'(CHANNELS));

  always_comb begin
    if (op_q == mcprd_pkg::OP_ACT_PROD) begin
      act_ok = ch_in_range && (ch_q <= prod_limit_q);
    end else begin
      act_ok = ch_in_range;
    end
  end

  assign ram_raddr = cnt_q[AW-1:0];
  assign ram_re    = (state_q == S_SWEEP) && (cnt_q < CNT_W'(CHANNELS));
  assign ram_waddr = wr_idx[AW-1:0];
  assign ram_wdata = {time_q, dur_q};
  assign ram_we    = (state_q == S_EXEC) && act_ok && ((new_ch_mask & online) != '0) &&
                     ((op_q == mcprd_pkg::OP_ACT_PROD) || (op_q == mcprd_pkg::OP_ACT_DIAG));

  mcprd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CHANNELS)
  ) u_timer_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    time_d   = time_q;
    last_d   = last_q;
    hold_d   = hold_q;
    tc_d     = tc_q;
    tb_d     = tb_q;
    phase_d  = phase_q;
    mode_d   = mode_q;
    en_d     = en_q;
    run_d    = run_q;
    status_d = status_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (mcprd_pkg::op_e'(s_axis_tdata[3:0]) == mcprd_pkg::OP_TICK) begin
            time_d   = time_q + 1'b1;
            cnt_d    = '0;
            status_d = mcprd_pkg::ST_OK;
            state_d  = S_SWEEP;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        status_d = mcprd_pkg::ST_OK;
        state_d  = S_DONE;
        case (op_q)
          mcprd_pkg::OP_ACT_PROD, mcprd_pkg::OP_ACT_DIAG: begin
            if (!act_ok) begin
              status_d = mcprd_pkg::ST_RANGE;
            end else if ((new_ch_mask & online) == '0) begin
              status_d = mcprd_pkg::ST_OFFLINE;
            end else begin
              en_d  = en_q | new_ch_mask;
              run_d = run_q | new_ch_mask;
            end
          end
          mcprd_pkg::OP_ALL_ON: begin
            en_d   = (en_q & ~cur_mask) | online;
            mode_d = mcprd_pkg::MODE_ALL_ON;
          end
          mcprd_pkg::OP_ALL_OFF: begin
            en_d   = en_q & ~cur_mask & ~online;
            mode_d = mcprd_pkg::MODE_ALL_OFF;
          end
          mcprd_pkg::OP_CYC_ALL: begin
            en_d    = (en_q & ~cur_mask) | online;
            mode_d  = mcprd_pkg::MODE_CYC_ALL;
            hold_d  = hold_in_q;
            phase_d = 1'b1;
            last_d  = time_q;
          end
          mcprd_pkg::OP_CYC_CH: begin
            en_d    = (en_q & ~cur_mask) | (new_ch_mask & online);
            mode_d  = mcprd_pkg::MODE_CYC_CH;
            hold_d  = hold_in_q;
            phase_d = 1'b1;
            last_d  = time_q;
            tc_d    = ch_q;
            if (!ch_in_range) begin
              status_d = mcprd_pkg::ST_RANGE;
            end else if ((new_ch_mask & online) == '0) begin
              status_d = mcprd_pkg::ST_OFFLINE;
            end
          end
          mcprd_pkg::OP_CYC_BD: begin
            en_d    = (en_q & ~cur_mask) | (new_bd_mask & online);
            mode_d  = mcprd_pkg::MODE_CYC_BD;
            hold_d  = hold_in_q;
            phase_d = 1'b1;
            last_d  = time_q;
            tb_d    = bd_q;
            if (!bd_up[bd_q]) begin
              status_d = mcprd_pkg::ST_OFFLINE;
            end
          end
          mcprd_pkg::OP_STOP: begin
            en_d   = en_q & ~cur_mask;
            mode_d = mcprd_pkg::MODE_NONE;
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        if (ram_re) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = S_TOGGLE;
        end
        if (rd_vld_q && run_q[rd_idx_q] && expired) begin
          en_d[rd_idx_q]  = en_q[rd_idx_q] & ~online[rd_idx_q];
          run_d[rd_idx_q] = 1'b0;
        end
      end
      S_TOGGLE: begin
        state_d = S_DONE;
        if ((mode_q == mcprd_pkg::MODE_CYC_ALL || mode_q == mcprd_pkg::MODE_CYC_CH ||
             mode_q == mcprd_pkg::MODE_CYC_BD) &&
            (since_toggle >= {{(TW - DW){1'b0}}, hold_q})) begin
          last_d  = time_q;
          phase_d = !phase_q;
          en_d    = phase_q ? (en_q & ~cur_mask) : (en_q | cur_mask);
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      time_q   <= '0;
      last_q   <= '0;
      hold_q   <= mcprd_pkg::DEFAULT_HOLD;
      tc_q     <= 6'd1;
      tb_q     <= 2'd0;
      phase_q  <= 1'b0;
      mode_q   <= mcprd_pkg::MODE_NONE;
      en_q     <= '0;
      run_q    <= '0;
      status_q <= mcprd_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= ram_re;
      rd_idx_q <= ram_raddr;
      time_q   <= time_d;
      last_q   <= last_d;
      hold_q   <= hold_d;
      tc_q     <= tc_d;
      tb_q     <= tb_d;
      phase_q  <= phase_d;
      mode_q   <= mode_d;
      en_q     <= en_d;
      run_q    <= run_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= mcprd_pkg::op_e'(s_axis_tdata[3:0]);
      ch_q      <= s_axis_tdata[9:4];
      bd_q      <= s_axis_tdata[11:10];
      dur_q     <= s_axis_tdata[35:12];
      hold_in_q <= s_axis_tdata[59:36];
    end
  end

  assign pin_full = (act_high_q ? en_q : ~en_q) & online;

  for (genvar k = 0; k < mcprd_pkg::PIN_W; k++) begin : g_pin
    if (k < CHANNELS) begin : g_drv
      assign pin_out[k] = pin_full[k];
    end else begin : g_zero
      assign pin_out[k] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {5'd0, phase_q, status_q, pin_out};
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_tick_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tdata[3:0] == mcprd_pkg::OP_TICK) |=> (state_q == S_SWEEP))
    else $error("tick did not start the timer sweep");

  a_sweep_only_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |=> ((en_q & ~$past(en_q)) == '0 && (run_q & ~$past(run_q)) == '0))
    else $error("timer sweep set a pin or a running flag");

  a_offline_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |=> (((en_q ^ $past(en_q)) & ~online) == '0))
    else $error("timer sweep changed a pin on an offline board");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("result presented outside the completion state");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for multi_channel_pulse_relay_driver.
// Needs mcprd_pkg and the driver RTL. Directed and random command streams go in
// over the stream port, register settings over APB, and a scoreboard checks each result.
module tb;

  localparam int unsigned NUM_CH      = 48;
  localparam int unsigned NUM_BD      = 3;
  localparam int unsigned PINS_BD     = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYC  = 60;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam logic [3:0]  OP_SPARE_LO = 4'd9;
  localparam logic [3:0]  OP_SPARE_HI = 4'd15;

  // hold_ms, duration_ms, board, channel, operation (operation in the low bits)
  typedef struct packed {
    logic [23:0] hold;
    logic [23:0] dur;
    logic [1:0]  board;
    logic [5:0]  ch;
    logic [3:0]  op;
  } relay_cmd_t;

  typedef struct packed {
    logic        phase;
    logic [1:0]  status;
    logic [47:0] pins;
  } relay_result_t;

  class relay_scoreboard;
    logic [2:0]  online_mask;
    logic        active_hi;
    logic [5:0]  prod_limit;

    logic [31:0] now_ms;
    logic        running [NUM_CH];
    logic [31:0] start_ms [NUM_CH];
    logic [23:0] pulse_ms [NUM_CH];
    logic [47:0] energized;
    logic [2:0]  mode;
    logic [23:0] hold_period;
    logic [5:0]  target_ch;
    logic [1:0]  target_bd;
    logic        phase_on;
    logic [31:0] last_toggle;

    relay_result_t expected_pins_q [$];
    int unsigned errors, n_results, n_ticks, n_pulses, n_tests, n_regs;

    function new();
      online_mask = '0;
      active_hi   = 1'b1;
      prod_limit  = 6'd47;
      now_ms      = '0;
      for (int i = 0; i < NUM_CH; i++) begin
        running[i]  = 1'b0;
        start_ms[i] = '0;
        pulse_ms[i] = '0;
      end
      energized   = '0;
      mode        = mcprd_pkg::MODE_NONE;
      hold_period = mcprd_pkg::DEFAULT_HOLD;
      target_ch   = 6'd1;
      target_bd   = '0;
      phase_on    = 1'b0;
      last_toggle = '0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH: %s", msg);
    endtask

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      n_regs++;
      case (idx)
        mcprd_pkg::REG_BOARD_MASK: online_mask = val[2:0];
        mcprd_pkg::REG_ACT_HIGH:   active_hi   = val[0];
        mcprd_pkg::REG_PROD_LIMIT: prod_limit  = val[5:0];
        default: ;
      endcase
    endfunction

    function bit board_on(int unsigned b);
      return (b < NUM_BD) ? online_mask[b] : 1'b0;
    endfunction

    function void set_pin(int unsigned idx, bit on);
      if (idx < NUM_CH && board_on(idx / PINS_BD)) energized[idx] = on;
    endfunction

    function void set_all(bit on);
      for (int unsigned i = 0; i < NUM_CH; i++) set_pin(i, on);
    endfunction

    function void set_board(int unsigned b, bit on);
      if (b >= NUM_BD) return;
      for (int unsigned p = 0; p < PINS_BD; p++) set_pin(b * PINS_BD + p, on);
    endfunction

    function void set_target(bit on);
      if (target_ch >= 1 && target_ch <= NUM_CH) set_pin(target_ch - 1, on);
    endfunction

    function void end_test();
      case (mode)
        mcprd_pkg::MODE_ALL_ON, mcprd_pkg::MODE_ALL_OFF,
        mcprd_pkg::MODE_CYC_ALL: set_all(1'b0);
        mcprd_pkg::MODE_CYC_CH: set_target(1'b0);
        mcprd_pkg::MODE_CYC_BD: set_board(target_bd, 1'b0);
        default: ;
      endcase
      mode = mcprd_pkg::MODE_NONE;
    endfunction

    function logic [1:0] arm_pulse(int unsigned ch, int unsigned limit, logic [23:0] dur);
      int unsigned idx;
      if (ch < 1 || ch > limit || ch > NUM_CH) return mcprd_pkg::ST_RANGE;
      idx = ch - 1;
      if (!board_on(idx / PINS_BD)) return mcprd_pkg::ST_OFFLINE;
      set_pin(idx, 1'b1);
      running[idx]  = 1'b1;
      start_ms[idx] = now_ms;
      pulse_ms[idx] = dur;
      return mcprd_pkg::ST_OK;
    endfunction

    function void begin_cycle(logic [2:0] m, logic [23:0] hold);
      end_test();
      mode        = m;
      hold_period = hold;
      phase_on    = 1'b1;
      last_toggle = now_ms;
    endfunction

    function void advance_ms();
      now_ms = now_ms + 1;
      for (int unsigned i = 0; i < NUM_CH; i++) begin
        if (running[i] && (now_ms - start_ms[i]) >= 32'(pulse_ms[i])) begin
          set_pin(i, 1'b0);
          running[i] = 1'b0;
        end
      end
      if (mode < mcprd_pkg::MODE_CYC_ALL || mode > mcprd_pkg::MODE_CYC_BD) return;
      if ((now_ms - last_toggle) < 32'(hold_period)) return;
      last_toggle = now_ms;
      phase_on    = !phase_on;
      if (mode == mcprd_pkg::MODE_CYC_ALL) set_all(phase_on);
      else if (mode == mcprd_pkg::MODE_CYC_CH) set_target(phase_on);
      else set_board(target_bd, phase_on);
    endfunction

    function logic [47:0] pin_levels();
      logic [47:0] on_mask;
      on_mask = '0;
      for (int unsigned b = 0; b < NUM_BD; b++)
        if (board_on(b)) on_mask[b*PINS_BD +: PINS_BD] = '1;
      return (active_hi ? energized : ~energized) & on_mask;
    endfunction

    function void note_command(relay_cmd_t c);
      relay_result_t r;
      logic [1:0]    st;
      st = mcprd_pkg::ST_OK;
      case (c.op)
        mcprd_pkg::OP_TICK: begin
          n_ticks++;
          advance_ms();
        end
        mcprd_pkg::OP_ACT_PROD: begin
          n_pulses++;
          st = arm_pulse(c.ch, prod_limit, c.dur);
        end
        mcprd_pkg::OP_ACT_DIAG: begin
          n_pulses++;
          st = arm_pulse(c.ch, NUM_CH, c.dur);
        end
        mcprd_pkg::OP_ALL_ON: begin
          n_tests++;
          end_test();
          set_all(1'b1);
          mode = mcprd_pkg::MODE_ALL_ON;
        end
        mcprd_pkg::OP_ALL_OFF: begin
          n_tests++;
          end_test();
          set_all(1'b0);
          mode = mcprd_pkg::MODE_ALL_OFF;
        end
        mcprd_pkg::OP_CYC_ALL: begin
          n_tests++;
          begin_cycle(mcprd_pkg::MODE_CYC_ALL, c.hold);
          set_all(1'b1);
        end
        mcprd_pkg::OP_CYC_CH: begin
          n_tests++;
          begin_cycle(mcprd_pkg::MODE_CYC_CH, c.hold);
          target_ch = c.ch;
          if (c.ch < 1 || c.ch > NUM_CH) st = mcprd_pkg::ST_RANGE;
          else if (!board_on((c.ch - 1) / PINS_BD)) st = mcprd_pkg::ST_OFFLINE;
          set_target(1'b1);
        end
        mcprd_pkg::OP_CYC_BD: begin
          n_tests++;
          begin_cycle(mcprd_pkg::MODE_CYC_BD, c.hold);
          target_bd = c.board;
          if (!board_on(c.board)) st = mcprd_pkg::ST_OFFLINE;
          set_board(c.board, 1'b1);
        end
        mcprd_pkg::OP_STOP: begin
          n_tests++;
          end_test();
        end
        default: ;
      endcase
      r.pins   = pin_levels();
      r.status = st;
      r.phase  = phase_on;
      expected_pins_q.push_back(r);
    endfunction

    task check_result(logic [55:0] d);
      relay_result_t got, want;
      got = d[50:0];
      n_results++;
      if (expected_pins_q.size() == 0) begin
        report($sformatf("result %0d arrived with no transaction pending", n_results));
        return;
      end
      want = expected_pins_q.pop_front();
      if (got.pins !== want.pins)
        report($sformatf("result %0d pin_levels %h, want %h", n_results, got.pins, want.pins));
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, want %0d", n_results, got.status, want.status));
      if (got.phase !== want.phase)
        report($sformatf("result %0d cycle_phase %0b, want %0b", n_results, got.phase,
                         want.phase));
    endtask

    function int unsigned pending();
      return expected_pins_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  relay_scoreboard sb;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  int unsigned     cycle_cnt = 0;

  multi_channel_pulse_relay_driver u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check on handshake, random backpressure
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic relay_cmd_t mk(logic [3:0] op, logic [5:0] ch, logic [1:0] bd,
                                    logic [23:0] dur, logic [23:0] hold);
    relay_cmd_t c;
    c.op    = op;
    c.ch    = ch;
    c.board = bd;
    c.dur   = dur;
    c.hold  = hold;
    return c;
  endfunction

  function automatic relay_cmd_t random_command();
    relay_cmd_t  c;
    int unsigned r;
    r       = $urandom_range(99);
    c.board = 2'($urandom_range(3));
    c.ch    = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(1, 48));
    c.dur   = ($urandom_range(6) == 0) ? 24'($urandom) : 24'($urandom_range(25));
    c.hold  = ($urandom_range(6) == 0) ? 24'($urandom) : 24'($urandom_range(8));
    if (r < 40)      c.op = mcprd_pkg::OP_TICK;
    else if (r < 55) c.op = mcprd_pkg::OP_ACT_PROD;
    else if (r < 70) c.op = mcprd_pkg::OP_ACT_DIAG;
    else if (r < 74) c.op = mcprd_pkg::OP_ALL_ON;
    else if (r < 77) c.op = mcprd_pkg::OP_ALL_OFF;
    else if (r < 81) c.op = mcprd_pkg::OP_CYC_ALL;
    else if (r < 86) c.op = mcprd_pkg::OP_CYC_CH;
    else if (r < 91) c.op = mcprd_pkg::OP_CYC_BD;
    else if (r < 96) c.op = mcprd_pkg::OP_STOP;
    else             c.op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    return c;
  endfunction

  // called just after a rising edge; returns at the edge the transaction is taken
  task automatic send_command(input relay_cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, c};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_command(c);
  endtask

  task automatic wait_drained(input bit settle);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned masks [PHASES];
    int unsigned highs [PHASES];
    int unsigned limits [PHASES];
    int unsigned sent;
    relay_cmd_t  c;
    bit          paused;

    masks  = '{7, 3, 0, 5, 6, 7};
    highs  = '{0, 1, 1, 0, 1, 1};
    limits = '{48, 1, 0, 63, 20, 47};
    masks[5]  = $urandom_range(7);
    highs[5]  = $urandom_range(1);
    limits[5] = $urandom_range(1, 48);
    paused    = 1'b0;

    sb            = new();
    clk           = 1'b0;
    rst_n         = 1'b0;
    tx_idle_pct   = 27;
    rx_idle_pct   = 80;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: all boards offline, production limit 47
    send_command(mk(mcprd_pkg::OP_ACT_PROD, 6'd48, 2'd0, 24'd3, 24'd0));
    send_command(mk(mcprd_pkg::OP_ACT_DIAG, 6'd5, 2'd0, 24'd3, 24'd0));
    send_command(mk(mcprd_pkg::OP_CYC_CH, 6'd5, 2'd0, 24'd0, 24'd2));
    send_command(mk(mcprd_pkg::OP_TICK, 6'd0, 2'd0, 24'd0, 24'd0));
    wait_drained(1'b1);
    apb_write(mcprd_pkg::REG_BOARD_MASK, 32'd7);
    apb_write(mcprd_pkg::REG_ACT_HIGH, 32'd1);
    apb_write(mcprd_pkg::REG_PROD_LIMIT, 32'd48);

    send_command(mk(mcprd_pkg::OP_ACT_DIAG, 6'd0, 2'd0, 24'd5, 24'd0));
    send_command(mk(mcprd_pkg::OP_ACT_PROD, 6'd63, 2'd3, 24'd5, 24'd0));
    send_command(mk(mcprd_pkg::OP_ACT_DIAG, 6'd49, 2'd0, 24'd5, 24'd0));
    send_command(mk(mcprd_pkg::OP_ACT_PROD, 6'd48, 2'd0, 24'd0, 24'd0));
    send_command(mk(mcprd_pkg::OP_ACT_DIAG, 6'd1, 2'd0, 24'd2, 24'd0));
    send_command(mk(mcprd_pkg::OP_ACT_DIAG, 6'd17, 2'd2, 24'hFFFFFF, 24'hFFFFFF));
    repeat (3) send_command(mk(mcprd_pkg::OP_TICK, 6'd0, 2'd0, 24'd0, 24'd0));
    send_command(mk(mcprd_pkg::OP_ALL_ON, 6'd0, 2'd0, 24'd0, 24'd0));
    send_command(mk(mcprd_pkg::OP_ALL_OFF, 6'd0, 2'd0, 24'd0, 24'd0));
    send_command(mk(mcprd_pkg::OP_CYC_ALL, 6'd0, 2'd0, 24'd0, 24'd0));
    repeat (2) send_command(mk(mcprd_pkg::OP_TICK, 6'd0, 2'd0, 24'd0, 24'd0));
    send_command(mk(mcprd_pkg::OP_CYC_CH, 6'd0, 2'd0, 24'd0, 24'd1));
    send_command(mk(mcprd_pkg::OP_CYC_CH, 6'd33, 2'd0, 24'd0, 24'd1));
    repeat (2) send_command(mk(mcprd_pkg::OP_TICK, 6'd0, 2'd0, 24'd0, 24'd0));
    send_command(mk(mcprd_pkg::OP_CYC_BD, 6'd0, 2'd3, 24'd0, 24'hFFFFFF));
    send_command(mk(mcprd_pkg::OP_CYC_BD, 6'd0, 2'd1, 24'd0, 24'd1));
    repeat (2) send_command(mk(mcprd_pkg::OP_TICK, 6'd0, 2'd0, 24'd0, 24'd0));
    send_command(mk(mcprd_pkg::OP_STOP, 6'd0, 2'd0, 24'd0, 24'd0));
    send_command(mk(OP_SPARE_HI, 6'h3F, 2'd3, 24'hFFFFFF, 24'hFFFFFF));
    send_command(mk(OP_SPARE_LO, 6'd0, 2'd0, 24'd0, 24'd0));

    for (int p = 0; p < PHASES; p++) begin
      wait_drained(1'b1);
      tx_idle_pct = (p < 2) ? 27 : (p < 4) ? 80 : 0;
      rx_idle_pct = (p < 2) ? 80 : (p < 4) ? 27 : 0;
      apb_write(mcprd_pkg::REG_BOARD_MASK, masks[p]);
      apb_write(mcprd_pkg::REG_ACT_HIGH, highs[p]);
      apb_write(mcprd_pkg::REG_PROD_LIMIT, limits[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        c = random_command();
        send_command(c);
        if (c.op <= mcprd_pkg::OP_STOP) sent++;
        if (p == 1 && sent == PHASE_ITEMS / 2 && !paused) begin
          paused = 1'b1;
          wait_drained(1'b0);
        end
      end
    end

    wait_drained(1'b1);
    $display("Ran %0d ticks, %0d activations and %0d test commands over %0d register writes",
             sb.n_ticks, sb.n_pulses, sb.n_tests, sb.n_regs);
    $display("Checked %0d results, %0d mismatches", sb.n_results, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
